/* hdl/ndc_pkg.sv */
// ----------------------------------------------------------------------------
// Neighbor cache package
// Shared constants, command and action codes and controller/datapath structs.
// ----------------------------------------------------------------------------
package ndc_pkg;

    localparam int DEF_BUCKETS = 64;
    localparam int DEF_WAYS    = 4;

    localparam logic [1:0] CMD_SEND  = 2'd0;
    localparam logic [1:0] CMD_ADV   = 2'd1;
    localparam logic [1:0] CMD_SWEEP = 2'd2;

    localparam logic [1:0] ACT_FWD   = 2'd0;
    localparam logic [1:0] ACT_SOL   = 2'd1;
    localparam logic [1:0] ACT_DROP  = 2'd2;
    localparam logic [1:0] ACT_FULL  = 2'd3;

    localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86DD;
    localparam logic [7:0]  ICMP_NADV      = 8'd136;

    localparam logic [31:0] POLL_AGE_RST   = 32'd60000;
    localparam logic [31:0] EXPIRE_AGE_RST = 32'd120000;

    localparam logic REG_POLL_AGE   = 1'b0;
    localparam logic REG_EXPIRE_AGE = 1'b1;

    // Payload of one cached entry held in memory. The flags count only while
    // the slot's valid bit is set.
    typedef struct packed {
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [47:0] mac;
        logic [15:0] pend;
        logic [31:0] reply;
        logic        resolved;
        logic        polling;
        logic        pending;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic        load;      // capture input item
        logic        rd;        // issue memory read of current slot
        logic        eval;      // evaluate read data for the way last read
        logic        decide;    // latch the result pair of the item
        logic        commit;    // write back the chosen slot
        logic        sweep_eval;// evaluate one slot during a sweep
        logic        out_load;  // load the next result into the output
        logic        out_second;// select second result
        logic        clr_cnt;
        logic        inc_cnt;
    } ndc_cmd_t;

    typedef struct packed {
        logic       cnt_last;   // current way/slot is the final one
        logic [1:0] n_res;      // results produced by this item
        logic       no_commit;
    } ndc_sts_t;

endpackage

/* hdl/ipv6_neighbor_cache_resolver_unit.sv */
// ----------------------------------------------------------------------------
// IPv6 neighbor cache resolver
// Set-associative neighbor cache with send, advertisement and sweep commands.
// ----------------------------------------------------------------------------
// Usage: one input transaction on the s_axis group carries a command with its
// address, handle, advertisement fields and current time. Each transaction
// yields zero, one or two result transactions on m_axis, the final one with
// tlast set. A send or advertisement reads the WAYS ways of its bucket from
// the entry memory, one per cycle, then decides and writes back in the same
// cycle, then delivers results. A sweep walks every slot, one per cycle, and
// gives no result. The single memory read port is why the reads go one at a
// time.
// Reset clears every valid bit, so the cache starts empty, and loads the
// default ages; the other entry flags live in the entry memory and count only
// for a valid slot, so no clearing pass is needed. The block holds one item
// at a time; s_axis_tready stays low while an item is in work. A result that
// waits in the output register does not hold off the next item, but that
// item waits at its first result until the receiver takes the old one, so a
// stalled receiver stalls the input.
// Configuration writes (0 poll_age, 1 expire_age) take effect at once; the user
// must make them while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module ipv6_neighbor_cache_resolver_unit
    import ndc_pkg::*;
#(
    parameter int BUCKETS = DEF_BUCKETS,
    parameter int WAYS    = DEF_WAYS
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // cmd[1:0], addr_high[65:2], addr_low[129:66], packet_handle[145:130],
    // adv_mac[193:146], adv_ether_type[209:194], adv_icmp_type[217:210],
    // adv_long_enough[218], now_ticks[250:219], zero fill to 256
    input  logic [255:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // action[1:0], out_handle[17:2], dest_mac[65:18], target_high[129:66],
    // target_low[193:130], zero fill to 200
    output logic [199:0] m_axis_tdata,
    output logic         m_axis_tlast,
    input  logic         cfg_we,
    input  logic [0:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    ndc_cmd_t ctl;
    ndc_sts_t sts;
    logic     s_fire;
    logic [1:0]  o_action;
    logic [15:0] o_handle;
    logic [47:0] o_mac;
    logic [63:0] o_th, o_tl;

    assign s_fire = s_axis_tvalid && s_axis_tready;

    ndc_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_fire  (s_fire),
        .s_cmd   (s_axis_tdata[1:0]),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .ctl     (ctl),
        .sts     (sts)
    );

    ndc_datapath #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .sts             (sts),
        .cmd             (s_axis_tdata[1:0]),
        .addr_high       (s_axis_tdata[65:2]),
        .addr_low        (s_axis_tdata[129:66]),
        .packet_handle   (s_axis_tdata[145:130]),
        .adv_mac         (s_axis_tdata[193:146]),
        .adv_ether_type  (s_axis_tdata[209:194]),
        .adv_icmp_type   (s_axis_tdata[217:210]),
        .adv_long_enough (s_axis_tdata[218]),
        .now_ticks       (s_axis_tdata[250:219]),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .o_action        (o_action),
        .o_handle        (o_handle),
        .o_mac           (o_mac),
        .o_th            (o_th),
        .o_tl            (o_tl),
        .o_last          (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, o_tl, o_th, o_mac, o_handle, o_action};

endmodule

/* hdl/ndc_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
module ndc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/ndc_datapath.sv */
// ----------------------------------------------------------------------------
// Neighbor cache datapath
// Item register, per-slot valid bits, entry memory, way scan and result builder.
// ----------------------------------------------------------------------------
module ndc_datapath
    import ndc_pkg::*;
#(
    parameter int BUCKETS = DEF_BUCKETS,
    parameter int WAYS    = DEF_WAYS
) (
    input  logic         clk,
    input  logic         rst_n,
    input  ndc_cmd_t     ctl,
    output ndc_sts_t     sts,
    input  logic [1:0]   cmd,
    input  logic [63:0]  addr_high,
    input  logic [63:0]  addr_low,
    input  logic [15:0]  packet_handle,
    input  logic [47:0]  adv_mac,
    input  logic [15:0]  adv_ether_type,
    input  logic [7:0]   adv_icmp_type,
    input  logic         adv_long_enough,
    input  logic [31:0]  now_ticks,
    input  logic         cfg_we,
    input  logic [0:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    output logic [1:0]   o_action,
    output logic [15:0]  o_handle,
    output logic [47:0]  o_mac,
    output logic [63:0]  o_th,
    output logic [63:0]  o_tl,
    output logic         o_last
);

    localparam int SLOTS = BUCKETS * WAYS;
    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CW    = SW + 1;

    logic [31:0] poll_age_reg, expire_age_reg;
    logic [1:0]  cmd_reg;
    logic [63:0] hi_reg, lo_reg;
    logic [15:0] hdl_reg;
    logic [47:0] mac_reg;
    logic        adv_ok_reg;
    logic [31:0] now_reg;
    logic [BW-1:0] bucket_reg;

    logic [SLOTS-1:0] valid_reg;
    logic [CW-1:0]    cnt_reg;

    // Scan results.
    logic          hit_reg, hit_next;
    logic [WW-1:0] hit_way_reg, hit_way_next;
    logic          free_reg, free_next;
    logic [WW-1:0] free_way_reg, free_way_next;
    entry_t        hit_ent_reg, hit_ent_next;

    // Result pair.
    logic [1:0]  r_act [2];
    logic [15:0] r_hdl [2];
    logic [47:0] r_mac [2];
    logic        r_tgt [2];
    logic [1:0]  nres;

    entry_t rdata, wdata;
    logic   we;
    logic [SW-1:0] waddr, raddr, cur_slot, tgt_slot;
    logic [8:0] bsum;

    assign bsum = {1'b0, addr_high[63:56]} + {1'b0, addr_low[7:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_age_reg   <= POLL_AGE_RST;
            expire_age_reg <= EXPIRE_AGE_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_POLL_AGE)
            begin
                poll_age_reg <= cfg_data;
            end
            else
            begin
                expire_age_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg    <= cmd;
            hi_reg     <= addr_high;
            lo_reg     <= addr_low;
            hdl_reg    <= packet_handle;
            mac_reg    <= adv_mac;
            now_reg    <= now_ticks;
            adv_ok_reg <= adv_long_enough && adv_ether_type == ETHERTYPE_IPV6
                          && adv_icmp_type == ICMP_NADV;
            bucket_reg <= BW'(bsum % 9'(BUCKETS));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctl.clr_cnt)
        begin
            cnt_reg <= '0;
        end
        else if (ctl.inc_cnt)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign cur_slot = (cmd_reg == CMD_SWEEP) ? cnt_reg[SW-1:0]
                    : SW'(SW'(bucket_reg) * SW'(WAYS) + SW'(cnt_reg[WW-1:0]));
    assign raddr = cur_slot;
    assign sts.cnt_last = (cmd_reg == CMD_SWEEP) ? (cnt_reg[SW-1:0] == SW'(SLOTS - 1))
                        : (cnt_reg[WW-1:0] == WW'(WAYS - 1));

    // Delayed slot/way for evaluating registered read data.
    logic [SW-1:0] ev_slot_reg;
    logic [WW-1:0] ev_way_reg;
    always_ff @(posedge clk)
    begin
        if (ctl.rd)
        begin
            ev_slot_reg <= cur_slot;
            ev_way_reg  <= cnt_reg[WW-1:0];
        end
    end

    always_comb
    begin
        hit_next      = hit_reg;
        hit_way_next  = hit_way_reg;
        hit_ent_next  = hit_ent_reg;
        free_next     = free_reg;
        free_way_next = free_way_reg;
        if (ctl.load)
        begin
            hit_next  = 1'b0;
            free_next = 1'b0;
        end
        else if (ctl.eval)
        begin
            if (!hit_reg && valid_reg[ev_slot_reg] && rdata.addr_high == hi_reg
                && rdata.addr_low == lo_reg)
            begin
                hit_next     = 1'b1;
                hit_way_next = ev_way_reg;
                hit_ent_next = rdata;
            end
            if (!free_reg && !valid_reg[ev_slot_reg])
            begin
                free_next     = 1'b1;
                free_way_next = ev_way_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end
        else
        begin
            hit_reg  <= hit_next;
            free_reg <= free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_way_reg  <= hit_way_next;
        hit_ent_reg  <= hit_ent_next;
        free_way_reg <= free_way_next;
    end

    logic [SW-1:0] hslot, fslot;
    assign hslot = SW'(SW'(bucket_reg) * SW'(WAYS) + SW'(hit_way_reg));
    assign fslot = SW'(SW'(bucket_reg) * SW'(WAYS) + SW'(free_way_reg));
    assign tgt_slot = hit_reg ? hslot : fslot;

    // Decide results and write-back for send and advertisement. The flags of
    // a hit come from the entry read during the scan.
    logic h_pol, h_res, h_pen;
    assign h_pol = hit_ent_reg.polling;
    assign h_res = hit_ent_reg.resolved;
    assign h_pen = hit_ent_reg.pending;

    always_comb
    begin
        nres = 2'd0;
        for (int i = 0; i < 2; i++)
        begin
            r_act[i] = ACT_FWD;
            r_hdl[i] = '0;
            r_mac[i] = '0;
            r_tgt[i] = 1'b0;
        end
        case (cmd_reg)
            CMD_SEND:
            begin
                if (hit_reg)
                begin
                    if (h_pol)
                    begin
                        r_act[0] = ACT_SOL;
                        r_tgt[0] = 1'b1;
                        r_hdl[1] = hdl_reg;
                        r_mac[1] = hit_ent_reg.mac;
                        nres = 2'd2;
                    end
                    else if (h_res)
                    begin
                        r_hdl[0] = hdl_reg;
                        r_mac[0] = hit_ent_reg.mac;
                        nres = 2'd1;
                    end
                    else if (h_pen)
                    begin
                        r_act[0] = ACT_DROP;
                        r_hdl[0] = hit_ent_reg.pend;
                        r_act[1] = ACT_SOL;
                        r_tgt[1] = 1'b1;
                        nres = 2'd2;
                    end
                    else
                    begin
                        r_act[0] = ACT_SOL;
                        r_tgt[0] = 1'b1;
                        nres = 2'd1;
                    end
                end
                else if (free_reg)
                begin
                    r_act[0] = ACT_SOL;
                    r_tgt[0] = 1'b1;
                    nres = 2'd1;
                end
                else
                begin
                    r_act[0] = ACT_FULL;
                    r_hdl[0] = hdl_reg;
                    nres = 2'd1;
                end
            end
            CMD_ADV:
            begin
                if (adv_ok_reg && hit_reg && h_pen)
                begin
                    r_hdl[0] = hit_ent_reg.pend;
                    r_mac[0] = mac_reg;
                    nres = 2'd1;
                end
            end
            default:
            begin
                nres = 2'd0;
            end
        endcase
    end

    assign sts.n_res = nres;
    assign sts.no_commit = (cmd_reg == CMD_ADV) ? !(adv_ok_reg && hit_reg)
                         : (cmd_reg == CMD_SEND) ? !(hit_reg || free_reg) : 1'b1;

    // Sweep age check on registered read data.
    logic [31:0] age;
    logic        sweep_hit, sweep_del, sweep_poll;
    assign age        = now_reg - rdata.reply;
    assign sweep_hit  = ctl.sweep_eval && valid_reg[ev_slot_reg] && rdata.resolved;
    assign sweep_del  = sweep_hit && age > expire_age_reg;
    assign sweep_poll = sweep_hit && !(age > expire_age_reg) && age > poll_age_reg;

    always_comb
    begin
        we    = 1'b0;
        waddr = tgt_slot;
        wdata = hit_ent_reg;
        if (ctl.commit)
        begin
            we = 1'b1;
            if (cmd_reg == CMD_SEND)
            begin
                wdata.pend    = hdl_reg;
                wdata.polling = 1'b0;
                if (!hit_reg)
                begin
                    wdata.addr_high = hi_reg;
                    wdata.addr_low  = lo_reg;
                    wdata.resolved  = 1'b0;
                    wdata.pending   = 1'b1;
                end
                else if (!h_res)
                begin
                    wdata.pending = 1'b1;
                end
            end
            else
            begin
                wdata.mac      = mac_reg;
                wdata.reply    = now_reg;
                wdata.resolved = 1'b1;
                wdata.polling  = 1'b0;
                wdata.pending  = 1'b0;
            end
        end
        else if (sweep_poll)
        begin
            // The sweep reads the next slot while it marks this one.
            we            = 1'b1;
            waddr         = ev_slot_reg;
            wdata         = rdata;
            wdata.polling = 1'b1;
        end
    end

    ndc_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctl.commit)
        begin
            if (cmd_reg == CMD_SEND)
            begin
                valid_reg[tgt_slot] <= 1'b1;
            end
        end
        else if (sweep_del)
        begin
            valid_reg[ev_slot_reg] <= 1'b0;
        end
    end

    // Result pair is captured in the decision cycle.
    logic [1:0]  p_act [2];
    logic [15:0] p_hdl [2];
    logic [47:0] p_mac [2];
    logic        p_tgt [2];
    logic [1:0]  p_n_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.decide)
        begin
            p_act <= r_act;
            p_hdl <= r_hdl;
            p_mac <= r_mac;
            p_tgt <= r_tgt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_n_reg <= 2'd0;
        end
        else if (ctl.decide)
        begin
            p_n_reg <= nres;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            o_action <= ctl.out_second ? p_act[1] : p_act[0];
            o_handle <= ctl.out_second ? p_hdl[1] : p_hdl[0];
            o_mac    <= ctl.out_second ? p_mac[1] : p_mac[0];
            o_th     <= (ctl.out_second ? p_tgt[1] : p_tgt[0]) ? hi_reg : 64'd0;
            o_tl     <= (ctl.out_second ? p_tgt[1] : p_tgt[0]) ? lo_reg : 64'd0;
            o_last   <= ctl.out_second || p_n_reg == 2'd1;
        end
    end

endmodule

/* hdl/ndc_ctrl.sv */
// ----------------------------------------------------------------------------
// Neighbor cache controller
// Sequences lookup, write-back, sweep and result delivery.
// ----------------------------------------------------------------------------
module ndc_ctrl
    import ndc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_fire,
    input  logic [1:0] s_cmd,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output ndc_cmd_t ctl,
    input  ndc_sts_t sts
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_LAST  = 3'd2;
    localparam logic [2:0] ST_DEC   = 3'd3;
    localparam logic [2:0] ST_OUT1  = 3'd4;
    localparam logic [2:0] ST_OUT2  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       mv_reg, mv_next;
    logic       two_reg, two_next;
    logic       sweep_reg, sweep_next;
    // Marks that the first read has been issued, so read data is valid.
    logic       cnt_started_reg;

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = mv_reg;

    always_comb
    begin
        state_next = state_reg;
        mv_next    = mv_reg && !m_ready;
        two_next   = two_reg;
        sweep_next = sweep_reg;
        ctl        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    ctl.load    = 1'b1;
                    ctl.clr_cnt = 1'b1;
                    sweep_next  = s_cmd == CMD_SWEEP;
                    state_next  = (s_cmd == CMD_SEND || s_cmd == CMD_ADV || s_cmd == CMD_SWEEP)
                                  ? ST_READ : ST_IDLE;
                end
            end
            ST_READ:
            begin
                ctl.rd      = 1'b1;
                ctl.inc_cnt = !sts.cnt_last;
                state_next  = sts.cnt_last ? ST_LAST : ST_READ;
                if (cnt_started_reg)
                begin
                    ctl.eval       = !sweep_reg;
                    ctl.sweep_eval = sweep_reg;
                end
            end
            ST_LAST:
            begin
                ctl.eval       = !sweep_reg;
                ctl.sweep_eval = sweep_reg;
                state_next     = sweep_reg ? ST_IDLE : ST_DEC;
            end
            ST_DEC:
            begin
                ctl.decide = 1'b1;
                ctl.commit = !sts.no_commit;
                two_next   = sts.n_res == 2'd2;
                state_next = (sts.n_res == 2'd0) ? ST_IDLE : ST_OUT1;
            end
            ST_OUT1:
            begin
                if (!mv_reg || m_ready)
                begin
                    ctl.out_load = 1'b1;
                    mv_next      = 1'b1;
                    state_next   = two_reg ? ST_OUT2 : ST_IDLE;
                end
            end
            ST_OUT2:
            begin
                if (!mv_reg || m_ready)
                begin
                    ctl.out_load   = 1'b1;
                    ctl.out_second = 1'b1;
                    mv_next        = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_started_reg <= 1'b0;
        end
        else
        begin
            cnt_started_reg <= state_reg == ST_READ;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mv_reg    <= 1'b0;
            two_reg   <= 1'b0;
            sweep_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
            two_reg   <= two_next;
            sweep_reg <= sweep_next;
        end
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |-> state_reg == ST_IDLE)
        else $error("item accepted while busy");
    a_out_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (mv_reg && !m_ready) |=> mv_reg)
        else $error("result lost under stall");
    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.commit, ctl.out_load, ctl.load}))
        else $error("conflicting commands");

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// Neighbor cache resolver testbench
// Drives send, advertisement and sweep transactions into the resolver with
// random idling on both sides, predicts every result from a behavioral copy
// of the cache, and compares each result transaction field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import ndc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NB = DEF_BUCKETS;
    localparam int NW = DEF_WAYS;
    localparam int NSLOT = NB * NW;
    localparam longint CYCLE_LIMIT = 3000000;

    // One result transaction as the block presents it.
    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] handle;
        logic [47:0] mac;
        logic [63:0] tgt_hi;
        logic [63:0] tgt_lo;
        logic        last;
    } result_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [255:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [199:0] m_axis_tdata;
    logic         m_axis_tlast;
    logic         cfg_we;
    logic [0:0]   cfg_index;
    logic [31:0]  cfg_data;

    ipv6_neighbor_cache_resolver_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Shadow copy of the cache and its two age registers.
    logic [31:0] poll_age_q, expire_age_q;
    logic        c_valid[NSLOT];
    logic        c_resolved[NSLOT];
    logic        c_polling[NSLOT];
    logic        c_pending[NSLOT];
    logic [63:0] c_hi[NSLOT];
    logic [63:0] c_lo[NSLOT];
    logic [47:0] c_mac[NSLOT];
    logic [15:0] c_phandle[NSLOT];
    logic [31:0] c_reply[NSLOT];

    result_t expected_results[$];
    int      error_count;
    longint  cycle_count;
    bit      idle_enable;     // random idling on both sides
    bit      receiver_hold;   // long receiver hold-off is active
    int      hold_cycles;

    // Addresses in use, so that random traffic mostly hits known entries.
    logic [63:0] known_hi[$];
    logic [63:0] known_lo[$];

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        error_count++;
    endtask

    function automatic int bucket_index(logic [63:0] hi, logic [63:0] lo);
        return (int'(hi[63:56]) + int'(lo[7:0])) % NB;
    endfunction

    function automatic int lookup_slot(logic [63:0] hi, logic [63:0] lo);
        int b;
        b = bucket_index(hi, lo);
        for (int w = 0; w < NW; w++)
            if (c_valid[b*NW+w] && c_hi[b*NW+w] == hi && c_lo[b*NW+w] == lo)
                return b * NW + w;
        return -1;
    endfunction

    function automatic result_t make_result(logic [1:0] act, logic [15:0] h,
                                            logic [47:0] m, logic [63:0] th,
                                            logic [63:0] tl);
        result_t r;
        r.action = act; r.handle = h; r.mac = m;
        r.tgt_hi = th; r.tgt_lo = tl; r.last = 1'b0;
        return r;
    endfunction

    // Works out the results of one accepted item and updates the shadow cache.
    task automatic predict_resolution(input logic [1:0] cmd, input logic [63:0] hi,
                                      input logic [63:0] lo, input logic [15:0] handle,
                                      input logic [47:0] mac, input logic [15:0] etype,
                                      input logic [7:0] itype, input logic longok,
                                      input logic [31:0] now);
        result_t res[$];
        int s;
        int b;
        logic [31:0] age;
        bit placed;
        if (cmd == CMD_SEND)
        begin
            s = lookup_slot(hi, lo);
            if (s >= 0)
            begin
                if (c_polling[s])
                begin
                    res.push_back(make_result(ACT_SOL, '0, '0, c_hi[s], c_lo[s]));
                    c_polling[s] = 1'b0;
                end
                if (c_resolved[s])
                    res.push_back(make_result(ACT_FWD, handle, c_mac[s], '0, '0));
                else
                begin
                    if (c_pending[s])
                        res.push_back(make_result(ACT_DROP, c_phandle[s], '0, '0, '0));
                    c_pending[s] = 1'b1;
                    c_phandle[s] = handle;
                    if (res.size() < 2)
                        res.push_back(make_result(ACT_SOL, '0, '0, hi, lo));
                end
            end
            else
            begin
                b = bucket_index(hi, lo);
                placed = 0;
                for (int w = 0; w < NW && !placed; w++)
                    if (!c_valid[b*NW+w])
                    begin
                        s = b * NW + w;
                        c_valid[s] = 1'b1; c_hi[s] = hi; c_lo[s] = lo;
                        c_resolved[s] = 1'b0; c_polling[s] = 1'b0;
                        c_pending[s] = 1'b1; c_phandle[s] = handle;
                        res.push_back(make_result(ACT_SOL, '0, '0, hi, lo));
                        placed = 1;
                    end
                if (!placed)
                    res.push_back(make_result(ACT_FULL, handle, '0, '0, '0));
            end
        end
        else if (cmd == CMD_ADV)
        begin
            if (longok && etype == ETHERTYPE_IPV6 && itype == ICMP_NADV)
            begin
                s = lookup_slot(hi, lo);
                if (s >= 0)
                begin
                    c_mac[s] = mac; c_resolved[s] = 1'b1;
                    c_polling[s] = 1'b0; c_reply[s] = now;
                    if (c_pending[s])
                    begin
                        c_pending[s] = 1'b0;
                        res.push_back(make_result(ACT_FWD, c_phandle[s], mac, '0, '0));
                    end
                end
            end
        end
        else if (cmd == CMD_SWEEP)
        begin
            for (int i = 0; i < NSLOT; i++)
                if (c_valid[i] && c_resolved[i])
                begin
                    age = now - c_reply[i];
                    if (age > expire_age_q)
                    begin
                        c_valid[i] = 1'b0; c_resolved[i] = 1'b0;
                        c_polling[i] = 1'b0; c_pending[i] = 1'b0;
                    end
                    else if (age > poll_age_q)
                        c_polling[i] = 1'b1;
                end
        end
        // The unused command code gives nothing.
        if (res.size() > 0)
            res[res.size()-1].last = 1'b1;
        foreach (res[k])
            expected_results.push_back(res[k]);
    endtask

    // Sends one item and waits for its transaction; prediction happens at
    // the accepting edge so that the shadow cache follows the block's order.
    // The block is busy after an accept, so the sender waits before it offers
    // the next item.
    task automatic send_item(input logic [1:0] cmd, input logic [63:0] hi,
                             input logic [63:0] lo, input logic [15:0] handle,
                             input logic [47:0] mac, input logic [15:0] etype,
                             input logic [7:0] itype, input logic longok,
                             input logic [31:0] now);
        do
            @(posedge clk);
        while (idle_enable && $urandom_range(99) < 30);
        s_axis_tdata <= {5'd0, now, longok, itype, etype, mac, handle, lo, hi, cmd};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_resolution(cmd, hi, lo, handle, mac, etype, itype, longok, now);
        s_axis_tvalid <= 1'b0;
        if (known_hi.size() < 200 && cmd == CMD_SEND)
        begin
            known_hi.push_back(hi);
            known_lo.push_back(lo);
        end
    endtask

    task automatic send_adv(input logic [63:0] hi, input logic [63:0] lo,
                            input logic [47:0] mac, input logic [31:0] now);
        send_item(CMD_ADV, hi, lo, '0, mac, ETHERTYPE_IPV6, ICMP_NADV, 1'b1, now);
    endtask

    // Waits until every expected result is out and the block has settled,
    // since a sweep or an ignored item may still be in work.
    task automatic drain_block();
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (NSLOT + 20)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [0:0] idx, input logic [31:0] value);
        drain_block();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_POLL_AGE)
            poll_age_q = value;
        else
            expire_age_q = value;
    endtask

    // Result checker: compares each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[1:0], m_axis_tdata[17:2], m_axis_tdata[65:18],
                   m_axis_tdata[129:66], m_axis_tdata[193:130], m_axis_tlast};
            if (expected_results.size() == 0)
                report_mismatch("result transaction with nothing expected");
            else
            begin
                want = expected_results.pop_front();
                if (got.action !== want.action)
                    report_mismatch($sformatf("action %0d want %0d", got.action, want.action));
                if (got.handle !== want.handle)
                    report_mismatch($sformatf("handle %h want %h", got.handle, want.handle));
                if (got.mac !== want.mac)
                    report_mismatch($sformatf("mac %h want %h", got.mac, want.mac));
                if (got.tgt_hi !== want.tgt_hi)
                    report_mismatch($sformatf("target_high %h want %h",
                                              got.tgt_hi, want.tgt_hi));
                if (got.tgt_lo !== want.tgt_lo)
                    report_mismatch($sformatf("target_low %h want %h",
                                              got.tgt_lo, want.tgt_lo));
                if (got.last !== want.last)
                    report_mismatch($sformatf("tlast %b want %b", got.last, want.last));
            end
        end
    end

    // Receiver readiness: random stalls, or a long hold-off when requested.
    always @(posedge clk)
    begin
        if (receiver_hold)
        begin
            m_axis_tready <= 1'b0;
            hold_cycles <= hold_cycles + 1;
            if (hold_cycles >= 400)
                receiver_hold <= 1'b0;
        end
        else
            m_axis_tready <= !(idle_enable && $urandom_range(99) < 30);
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Directed checks of the field extremes and every special case.
    task automatic test_directed();
        logic [63:0] hi;
        logic [63:0] lo;
        hi = 64'h2001_0db8_0000_0001;
        lo = 64'h0000_0000_0000_0005;
        send_item(CMD_SEND, hi, lo, 16'h0000, '0, '0, '0, 0, 32'd0);     // new entry
        send_item(CMD_SEND, hi, lo, 16'hFFFF, '0, '0, '0, 0, 32'd0);     // drop old pending
        send_item(CMD_ADV, hi, lo, '0, 48'hFFFF_FFFF_FFFF, 16'h86DC, ICMP_NADV, 1, 0);
        send_item(CMD_ADV, hi, lo, '0, 48'hFFFF_FFFF_FFFF, ETHERTYPE_IPV6, 8'd135, 1, 0);
        send_item(CMD_ADV, hi, lo, '0, 48'hFFFF_FFFF_FFFF, ETHERTYPE_IPV6, ICMP_NADV, 0, 0);
        send_adv(hi, lo, 48'hFFFF_FFFF_FFFF, 32'd100);                  // release
        send_item(CMD_SEND, hi, lo, 16'h1234, '0, '0, '0, 0, 32'd0);     // forward
        send_adv(hi, lo, 48'h0000_0000_0001, 32'd200);                  // overwrite
        send_adv(~hi, ~lo, 48'h1, 32'd0);                               // no entry
        // Fill one bucket: first byte 0xFF plus last byte 0x41 is bucket 0.
        for (int i = 0; i < NW + 1; i++)
            send_item(CMD_SEND, 64'hFF00_0000_0000_0000 | i, 64'hFFFF_FFFF_FFFF_FF41,
                      16'(i), '0, '0, '0, 0, 0);
        send_item(CMD_SWEEP, '0, '0, '0, '0, '0, '0, 0, 32'd60301);     // poll
        send_item(CMD_SEND, hi, lo, 16'h00AA, '0, '0, '0, 0, 32'd0);     // poll + forward
        send_item(2'd3, rand64(), rand64(), 16'hFFFF, '1, '1, '1, 1, '1); // unused code
        send_item(CMD_SWEEP, '0, '0, '0, '0, '0, '0, 0, 32'hFFFF_FFFF); // largest time, delete
        send_item(CMD_SEND, hi, lo, 16'h5555, '0, '0, '0, 0, 32'd0);
    endtask

    // Register extremes: tiny ages make every sweep poll or delete.
    task automatic test_register_extremes();
        write_register(REG_POLL_AGE, 32'd1);
        write_register(REG_EXPIRE_AGE, 32'hFFFF_FFFF);
        run_random(120);
        write_register(REG_EXPIRE_AGE, 32'd1);
        run_random(80);
        write_register(REG_POLL_AGE, 32'hFFFF_FFFF);
        write_register(REG_EXPIRE_AGE, 32'd3000);
        run_random(80);
        write_register(REG_POLL_AGE, 32'd500);
        run_random(150);
    endtask

    // Mostly well-formed traffic on a small address pool, with some noise.
    task automatic run_random(input int count);
        logic [63:0] hi;
        logic [63:0] lo;
        int pick;
        int k;
        logic [31:0] now;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            now = $urandom_range(99) < 80 ? 32'($urandom_range(6000)) : $urandom();
            if (known_hi.size() == 0 || $urandom_range(99) < 25)
            begin
                hi = rand64();
                lo = rand64();
                // Crowd some buckets so that full buckets occur.
                if ($urandom_range(1))
                begin
                    hi[63:56] = 8'($urandom_range(3));
                    lo[7:0] = 8'h00;
                end
            end
            else
            begin
                k = $urandom_range(known_hi.size() - 1);
                hi = known_hi[k];
                lo = known_lo[k];
            end
            if (pick < 45)
                send_item(CMD_SEND, hi, lo, 16'($urandom()), '0, '0, '0, 0, now);
            else if (pick < 80)
                send_adv(hi, lo, 48'({$urandom(), $urandom()}), now);
            else if (pick < 88)
                send_item(CMD_ADV, hi, lo, 16'($urandom()), 48'({$urandom(), $urandom()}),
                          $urandom_range(1) ? ETHERTYPE_IPV6 : 16'($urandom()),
                          $urandom_range(1) ? ICMP_NADV : 8'($urandom()),
                          1'($urandom()), now);
            else if (pick < 96)
                send_item(CMD_SWEEP, rand64(), rand64(), 16'($urandom()),
                          48'({$urandom(), $urandom()}), 16'($urandom()),
                          8'($urandom()), 1'($urandom()), now);
            else
                send_item(2'd3, rand64(), rand64(), 16'($urandom()), '1, '1, '1, 1, now);
        end
    endtask

    // The receiver holds off while items keep coming, so the input stalls.
    task automatic test_backpressure();
        hold_cycles <= 0;
        receiver_hold <= 1'b1;
        run_random(30);
    endtask

    // Random traffic with short ages and a stretch without idling.
    task automatic test_random_traffic();
        write_register(REG_POLL_AGE, 32'd2000);
        write_register(REG_EXPIRE_AGE, 32'd4000);
        run_random(200);
        idle_enable = 0;
        run_random(100);
        idle_enable = 1;
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        error_count = 0;
        cycle_count = 0;
        idle_enable = 1;
        receiver_hold = 0;
        hold_cycles = 0;
        poll_age_q = POLL_AGE_RST;
        expire_age_q = EXPIRE_AGE_RST;
        for (int i = 0; i < NSLOT; i++)
        begin
            c_valid[i] = 0; c_resolved[i] = 0; c_polling[i] = 0; c_pending[i] = 0;
            c_hi[i] = '0; c_lo[i] = '0; c_mac[i] = '0; c_phandle[i] = '0; c_reply[i] = '0;
        end
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_random_traffic();
        test_register_extremes();

        drain_block();
        if (error_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
